// File: hw/rtl/nspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_pkg
// Types, codes and helpers shared by the NSP header decoder modules.
// ----------------------------------------------------------------------------
package nspd_pkg;

  localparam int MAX_PAYLOAD_DEF = 2048;
  localparam int HDR_LEN         = 5;
  localparam int POS_W           = 12;
  localparam int POS_MAX         = 4095;
  localparam int RES_DEPTH       = 4;
  localparam int RES_PTR_W       = $clog2(RES_DEPTH);
  localparam int RES_CNT_W       = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_DATA = 3'd1,
    KIND_ACK  = 3'd2,
    KIND_CI   = 3'd3,
    KIND_CC   = 3'd4,
    KIND_DI   = 3'd5
  } pdu_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_TYPE = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_e;

  typedef enum logic {
    RES_PAYLOAD = 1'b0,
    RES_SUMMARY = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       end_of_pdu;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    status_e      status;
    pdu_kind_e    pdu_kind;
    logic [7:0]   flag_byte;
    logic [15:0]  dest_link;
    logic [15:0]  source_link;
    logic [15:0]  services_info;
    logic [15:0]  main_word;
    logic [15:0]  extra_ack;
    logic         extra_ack_present;
    logic [7:0]   payload_byte;
    logic [11:0]  payload_length;
  } out_item_t;

  // Up to two results per byte: a payload byte, then the summary
  typedef struct packed {
    logic      pay_valid;
    logic      sum_valid;
    out_item_t pay;
    out_item_t sum;
  } res_pair_t;

  // Message flag classification
  function automatic pdu_kind_e classify(input logic [7:0] f);
    pdu_kind_e k;
    k = KIND_NONE;
    case (f[3:2])
      2'b00: k = KIND_DATA;
      2'b01: k = (f == 8'h04) ? KIND_ACK : KIND_NONE;
      2'b10: begin
        case (f[7:4])
          4'h1:    k = KIND_CI;
          4'h2:    k = KIND_CC;
          4'h3:    k = KIND_DI;
          default: k = KIND_NONE;
        endcase
      end
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/nsp_pdu_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_pdu_decoder_core
// Streaming NSP header decoder: byte in, payload bytes and a summary out.
// ----------------------------------------------------------------------------
// Accepts one PDU byte per cycle while not stalled. A byte is held in an input
// register and decoded from there against the captured header state once the
// queue has room for a result pair; its results enter a four-entry result queue
// whose head drives the output port. Most bytes yield at most one result; the
// last byte of a PDU yields two when it is itself a kept payload byte (the
// payload byte, then the summary). The queue hands out one result per cycle
// unless the output side stalls, so with the output never stalled it holds at
// most two results and the input never stalls; input stalls only while three or
// more results are queued, which takes earlier stalls on the output side.
module nsp_pdu_decoder_core import nspd_pkg::*; #(
  parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      in_vld_q, in_vld_d;
  in_item_t  in_q;
  logic      room2;
  logic      take;
  res_pair_t res;

  // Input register: drained when the queue has room for a result pair
  assign take       = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !room2;
  assign in_vld_d   = (in_valid_i && !in_stall_o) ? 1'b1 : (take ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
  end

  nspd_parser #(
    .MaxPayload(MaxPayload)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .item_i(in_q),
    .res_o (res)
  );

  nspd_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .room2_o    (room2),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: hw/rtl/nspd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_parser
// Per-byte header field capture and result generation for one PDU stream.
// ----------------------------------------------------------------------------
module nspd_parser import nspd_pkg::*; #(
  parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  in_item_t  item_i,
  output res_pair_t res_o
);

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       flag;
    pdu_kind_e        kind;
    logic [15:0]      dest;
    logic [15:0]      source;
    logic [15:0]      svc_info;
    logic [15:0]      main;
    logic [15:0]      extra;
    logic             ack_seen;
    logic [7:0]       held;
    logic [11:0]      pay_cnt;
    logic             too_long;
  } pstate_t;

  localparam logic [11:0] MaxPay = 12'(MaxPayload);

  pstate_t st_q, st_d, upd;
  logic [7:0]       b;
  logic [15:0]      word;
  logic             is_pay;
  logic             pay_emit;
  logic [POS_W:0]   len;
  logic [POS_W:0]   need;
  status_e          status;

  assign b    = item_i.pdu_byte;
  assign word = {b, st_q.held};
  assign len  = {1'b0, st_q.pos} + 13'd1;

  // Field capture by byte position and type
  always_comb begin
    upd    = st_q;
    is_pay = 1'b0;
    if (st_q.pos == '0) begin
      upd.flag = b;
      upd.kind = classify(b);
    end else if (st_q.pos == 12'd1 || st_q.pos == 12'd3) begin
      upd.held = b;
    end else if (st_q.pos == 12'd2) begin
      upd.dest = word;
    end else if (st_q.pos == 12'd4) begin
      upd.source = word;
    end else if (st_q.kind == KIND_CI || st_q.kind == KIND_CC) begin
      if (st_q.pos == 12'd5)      upd.svc_info = {8'h00, b};
      else if (st_q.pos == 12'd6) upd.svc_info = {b, st_q.svc_info[7:0]};
      else if (st_q.pos == 12'd7) upd.held = b;
      else if (st_q.pos == 12'd8) upd.main = word;
      else                        is_pay = 1'b1;
    end else if (st_q.kind == KIND_DI) begin
      if (st_q.pos == 12'd5)      upd.held = b;
      else if (st_q.pos == 12'd6) upd.main = word;
      else                        is_pay = 1'b1;
    end else if (st_q.kind == KIND_ACK) begin
      if (st_q.pos == 12'd5 || st_q.pos == 12'd7) begin
        upd.held = b;
      end else if (st_q.pos == 12'd6) begin
        upd.main = word;
      end else if (st_q.pos == 12'd8) begin
        upd.extra    = word;
        upd.ack_seen = 1'b1;
      end
    end else if (st_q.kind == KIND_DATA) begin
      if (st_q.pos == 12'd5) begin
        upd.held = b;
      end else if (st_q.pos == 12'd6) begin
        if (word[15]) begin
          upd.extra    = word;
          upd.ack_seen = 1'b1;
        end else begin
          upd.main = word;
        end
      end else if (st_q.ack_seen && st_q.pos == 12'd7) begin
        upd.held = b;
      end else if (st_q.ack_seen && st_q.pos == 12'd8) begin
        upd.main = word;
      end else begin
        is_pay = 1'b1;
      end
    end

    // Payload count saturates; excess bytes are dropped and flagged
    pay_emit = 1'b0;
    if (is_pay) begin
      if (st_q.pay_cnt < MaxPay) begin
        upd.pay_cnt = st_q.pay_cnt + 12'd1;
        pay_emit    = 1'b1;
      end else begin
        upd.too_long = 1'b1;
      end
    end

    if (st_q.pos != POS_W'(POS_MAX)) upd.pos = st_q.pos + 12'd1;
  end

  // Summary status, in priority order
  always_comb begin
    if (upd.kind == KIND_CI || upd.kind == KIND_CC) need = 13'd9;
    else if (upd.kind == KIND_DATA)                 need = upd.ack_seen ? 13'd9 : 13'd7;
    else                                            need = 13'd7;

    if (len < 13'(HDR_LEN))        status = ST_TRUNC;
    else if (upd.kind == KIND_NONE) status = ST_BAD_TYPE;
    else if (len < need)            status = ST_TRUNC;
    else if (upd.kind == KIND_ACK)
      status = (len == 13'd7 || len == 13'd9) ? ST_OK : ST_BAD_LEN;
    else if (upd.too_long)          status = ST_BAD_LEN;
    else                            status = ST_OK;
  end

  // Result items
  always_comb begin
    res_o.pay.result_kind       = RES_PAYLOAD;
    res_o.pay.status            = ST_OK;
    res_o.pay.pdu_kind          = upd.kind;
    res_o.pay.flag_byte         = upd.flag;
    res_o.pay.dest_link         = upd.dest;
    res_o.pay.source_link       = upd.source;
    res_o.pay.services_info     = upd.svc_info;
    res_o.pay.main_word         = upd.main;
    res_o.pay.extra_ack         = upd.extra;
    res_o.pay.extra_ack_present = upd.ack_seen;
    res_o.pay.payload_byte      = b;
    res_o.pay.payload_length    = upd.pay_cnt;

    res_o.sum              = res_o.pay;
    res_o.sum.result_kind  = RES_SUMMARY;
    res_o.sum.status       = status;
    res_o.sum.payload_byte = 8'h00;

    res_o.pay_valid = take_i && pay_emit;
    res_o.sum_valid = take_i && item_i.end_of_pdu;
  end

  // Back to reset state after the last byte
  always_comb begin
    st_d = st_q;
    if (take_i) st_d = item_i.end_of_pdu ? '0 : upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // Checks
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.end_of_pdu |=> st_q.pos == '0 && st_q.pay_cnt == '0)
    else $error("parser did not restart after last byte");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pay_cnt <= MaxPay)
    else $error("payload count above maximum");

endmodule

// File: hw/rtl/nspd_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_res_fifo
// Small result queue: takes up to two results a cycle, hands out one when not stalled.
// ----------------------------------------------------------------------------
module nspd_res_fifo import nspd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t push_i,
  output logic      room2_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  out_item_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [RES_CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]             n_push;
  logic                   pop;
  out_item_t              first;
  logic [RES_PTR_W-1:0]   wr_nx;

  assign n_push = {1'b0, push_i.pay_valid} + {1'b0, push_i.sum_valid};
  assign first  = push_i.pay_valid ? push_i.pay : push_i.sum;
  assign wr_nx  = wr_q + RES_PTR_W'(1);
  assign pop    = (cnt_q != '0) && !out_stall_i;

  assign room2_o     = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + RES_PTR_W'(n_push);
    rd_d  = pop ? rd_q + RES_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage; payload result goes ahead of the summary
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem[wr_q] <= first;
    if (n_push == 2'd2) mem[wr_nx] <= push_i.sum;
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push != 2'd0 |-> ({1'b0, cnt_q} + {2'b0, n_push}) <= (RES_CNT_W + 1)'(RES_DEPTH))
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(RES_DEPTH))
    else $error("result count out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push == 2'd0 && !pop |=> $stable(cnt_q) && $stable(rd_q))
    else $error("queue changed without a transfer");

endmodule

// File: tb/sv/nsp_pdu_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_pdu_decoder_core_test
// Self-checking bench for the streaming NSP header decoder. PDUs are fed one
// byte per transfer. A behavioral decoder inside the bench predicts every
// payload byte and end summary, and each output transfer is compared field by
// field. A short directed table runs first, then random PDUs under several
// sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module nsp_pdu_decoder_core_test import nspd_pkg::*; ;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_BYTES = 250;

  // Directed stimulus row: byte, last marker, and optionally a typed summary
  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       last;
    logic       pinned;
    status_e    status;
    pdu_kind_e  kind;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int mismatches = 0;

  // Predicted decoder results, oldest first
  out_item_t pending_results[$];

  // Header capture state of the predictor
  logic [11:0] rx_pos;
  logic [7:0]  hdr_flag;
  pdu_kind_e   hdr_kind;
  logic [15:0] hdr_dest;
  logic [15:0] hdr_src;
  logic [15:0] hdr_svc;
  logic [15:0] hdr_main;
  logic [15:0] hdr_xack;
  logic        xack_seen;
  logic [7:0]  low_hold;
  logic [11:0] pay_cnt;
  logic        pay_over;

  plan_row_t plan_rows [29] = '{
    // one-byte PDU
    '{8'hFF, 1'b1, 1'b1, ST_TRUNC, KIND_NONE},
    // ack, dest 0000, source FFFF, acknum 1234
    '{8'h04, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h00, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h00, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'hFF, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'hFF, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h34, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h12, 1'b1, 1'b1, ST_OK, KIND_ACK},
    // connect initiate cut inside its header
    '{8'h1B, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'hFF, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'hFF, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h00, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h00, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h5A, 1'b1, 1'b1, ST_TRUNC, KIND_CI},
    // reserved flag class
    '{8'h0C, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h11, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h22, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h33, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h44, 1'b1, 1'b1, ST_BAD_TYPE, KIND_NONE},
    // data with piggyback ack 8000, segnum 0005, one payload byte
    '{8'h00, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h01, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h02, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h03, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h04, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h00, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h80, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h05, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'h00, 1'b0, 1'b0, ST_OK, KIND_NONE},
    '{8'hAA, 1'b1, 1'b0, ST_OK, KIND_NONE}
  };

  nsp_pdu_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Flag byte to PDU type
  function automatic pdu_kind_e kind_of_flag(input logic [7:0] f);
    if (f[3:2] == 2'b00) return KIND_DATA;
    if (f == 8'h04) return KIND_ACK;
    if (f[3:2] == 2'b10) begin
      if (f[7:4] == 4'h1) return KIND_CI;
      if (f[7:4] == 4'h2) return KIND_CC;
      if (f[7:4] == 4'h3) return KIND_DI;
    end
    return KIND_NONE;
  endfunction

  function automatic out_item_t make_result(input result_kind_e rk, input status_e st,
                                            input logic [7:0] pb);
    out_item_t r;
    r.result_kind       = rk;
    r.status            = st;
    r.pdu_kind          = hdr_kind;
    r.flag_byte         = hdr_flag;
    r.dest_link         = hdr_dest;
    r.source_link       = hdr_src;
    r.services_info     = hdr_svc;
    r.main_word         = hdr_main;
    r.extra_ack         = hdr_xack;
    r.extra_ack_present = xack_seen;
    r.payload_byte      = pb;
    r.payload_length    = pay_cnt;
    return r;
  endfunction

  task automatic clear_header();
    rx_pos    = '0;
    hdr_flag  = '0;
    hdr_kind  = KIND_NONE;
    hdr_dest  = '0;
    hdr_src   = '0;
    hdr_svc   = '0;
    hdr_main  = '0;
    hdr_xack  = '0;
    xack_seen = 1'b0;
    low_hold  = '0;
    pay_cnt   = '0;
    pay_over  = 1'b0;
  endtask

  // Advance the predictor by one accepted byte and queue what it yields
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [11:0] p;
    logic [15:0] w;
    logic        pay;
    int          len;
    int          need;
    status_e     st;
    p   = rx_pos;
    w   = {b, low_hold};
    pay = 1'b0;
    if (p == 0) begin
      hdr_flag = b;
      hdr_kind = kind_of_flag(b);
    end else if (p == 1 || p == 3) begin
      low_hold = b;
    end else if (p == 2) begin
      hdr_dest = w;
    end else if (p == 4) begin
      hdr_src = w;
    end else begin
      case (hdr_kind)
        KIND_CI, KIND_CC: begin
          if (p == 5) hdr_svc = {8'h00, b};
          else if (p == 6) hdr_svc = {b, hdr_svc[7:0]};
          else if (p == 7) low_hold = b;
          else if (p == 8) hdr_main = w;
          else pay = 1'b1;
        end
        KIND_DI: begin
          if (p == 5) low_hold = b;
          else if (p == 6) hdr_main = w;
          else pay = 1'b1;
        end
        KIND_ACK: begin
          if (p == 5 || p == 7) low_hold = b;
          else if (p == 6) hdr_main = w;
          else if (p == 8) begin
            hdr_xack  = w;
            xack_seen = 1'b1;
          end
        end
        KIND_DATA: begin
          if (p == 5) low_hold = b;
          else if (p == 6) begin
            // bit 15 marks a piggyback ack ahead of the segment number
            if (w[15]) begin
              hdr_xack  = w;
              xack_seen = 1'b1;
            end else begin
              hdr_main = w;
            end
          end else if (xack_seen && p == 7) low_hold = b;
          else if (xack_seen && p == 8) hdr_main = w;
          else pay = 1'b1;
        end
        default: ;
      endcase
    end

    // Payload past the maximum is dropped but remembered
    if (pay) begin
      if (pay_cnt < MAX_PAYLOAD_DEF) begin
        pay_cnt = pay_cnt + 12'd1;
        pending_results.push_back(make_result(RES_PAYLOAD, ST_OK, b));
      end else begin
        pay_over = 1'b1;
      end
    end
    if (rx_pos < POS_MAX) rx_pos = rx_pos + 12'd1;

    // End summary, status checks in priority order
    if (last) begin
      len = int'(p) + 1;
      if (hdr_kind == KIND_CI || hdr_kind == KIND_CC) need = 9;
      else if (hdr_kind == KIND_DATA && xack_seen) need = 9;
      else need = 7;
      if (len < HDR_LEN) st = ST_TRUNC;
      else if (hdr_kind == KIND_NONE) st = ST_BAD_TYPE;
      else if (len < need) st = ST_TRUNC;
      else if (hdr_kind == KIND_ACK) st = (len == 7 || len == 9) ? ST_OK : ST_BAD_LEN;
      else if (pay_over) st = ST_BAD_LEN;
      else st = ST_OK;
      pending_results.push_back(make_result(RES_SUMMARY, st, 8'h00));
      clear_header();
    end
  endtask

  // One byte transfer; called at a rising edge, returns at the accepting edge
  task automatic put_byte(input logic [7:0] b, input logic last);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pdu_byte: b, end_of_pdu: last};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    decode_byte(b, last);
    bytes_sent++;
  endtask

  // Build and send one PDU; sel < 0 picks a random type, npay < 0 a random size
  task automatic send_pdu(input int sel, input int npay);
    logic [7:0] f;
    logic [7:0] b6;
    logic [7:0] b;
    int         hdr;
    int         len;
    int         hi;
    logic       free_size;
    free_size = (npay < 0);
    if (sel < 0) sel = $urandom_range(99);
    b6 = 8'($urandom);
    if (free_size) begin
      npay = ($urandom_range(19) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
    end
    if (sel < 30) begin
      f   = 8'($urandom) & 8'hF3;
      hdr = b6[7] ? 9 : 7;
    end else if (sel < 45) begin
      f   = 8'h04;
      hdr = 7;
      // mostly 7 or 9 bytes in all, sometimes a wrong length
      case ($urandom_range(3))
        0:       npay = $urandom_range(0, 4);
        1:       npay = 2;
        default: npay = 0;
      endcase
    end else if (sel < 57) begin
      f   = {4'h1, 2'b10, 2'($urandom)};
      hdr = 9;
    end else if (sel < 69) begin
      f   = {4'h2, 2'b10, 2'($urandom)};
      hdr = 9;
    end else if (sel < 81) begin
      f   = {4'h3, 2'b10, 2'($urandom)};
      hdr = 7;
    end else begin
      hdr = 5;
      case ($urandom_range(2))
        0: f = 8'($urandom) | 8'h0C;
        1: begin
          f = (8'($urandom) & 8'hF3) | 8'h04;
          if (f == 8'h04) f = 8'h14;
        end
        default: begin
          hi = $urandom_range(0, 12);
          if (hi != 0) hi = hi + 3;
          f = {4'(hi), 2'b10, 2'($urandom)};
        end
      endcase
    end
    len = hdr + npay;
    if (free_size && $urandom_range(9) == 0) len = $urandom_range(1, hdr);
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = f;
      else if (i == 6) b = b6;
      else b = 8'($urandom);
      put_byte(b, i == len - 1);
    end
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want,
                           input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: got %h", got);
      return;
    end
    want = pending_results.pop_front();
    cmp_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
    cmp_field("status", 16'(want.status), 16'(got.status));
    cmp_field("pdu_kind", 16'(want.pdu_kind), 16'(got.pdu_kind));
    cmp_field("flag_byte", 16'(want.flag_byte), 16'(got.flag_byte));
    cmp_field("dest_link", want.dest_link, got.dest_link);
    cmp_field("source_link", want.source_link, got.source_link);
    cmp_field("services_info", want.services_info, got.services_info);
    cmp_field("main_word", want.main_word, got.main_word);
    cmp_field("extra_ack", want.extra_ack, got.extra_ack);
    cmp_field("extra_ack_present", 16'(want.extra_ack_present),
              16'(got.extra_ack_present));
    cmp_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
    cmp_field("payload_length", 16'(want.payload_length), 16'(got.payload_length));
  endtask

  // Output transfers, sampled mid-cycle where everything is settled
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // Watchdog on cycles with no transfer on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("nsp_pdu_decoder_core_test: done, errors");
    $finish;
  end

  // Main sequence
  initial begin
    int phase_start;
    clear_header();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (plan_rows[i]) begin
      put_byte(plan_rows[i].pdu_byte, plan_rows[i].last);
      if (plan_rows[i].pinned) begin
        pending_results[$].status   = plan_rows[i].status;
        pending_results[$].pdu_kind = plan_rows[i].kind;
      end
    end

    // Random PDUs under changing idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 71; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 71; end
        default: begin idle_pct = 33; stall_pct <= 33; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_pdu(-1, -1);
      // hold off until the decoder has drained
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("nsp_pdu_decoder_core_test: done, clean");
    end else begin
      $display("nsp_pdu_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule

// File: nsp_pdu_decoder_core.f
hw/rtl/nspd_pkg.sv
hw/rtl/nspd_parser.sv
hw/rtl/nspd_res_fifo.sv
hw/rtl/nsp_pdu_decoder_core.sv
tb/sv/nsp_pdu_decoder_core_test.sv
